[hw/rtl/mvi_pkg.sv]
// ----------------------------------------------------------------------------
// mvi_pkg
// shared types, constants and sequencing tables for the mesh volume integrals
// block
// ----------------------------------------------------------------------------
package mvi_pkg;

    localparam int FIELD_W     = 10;
    localparam int COORD_BITS  = 10;
    localparam int NUM_MOMENTS = 10;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 64;
    localparam int A_W         = 24;
    localparam int B_W         = 36;
    localparam int P_W         = A_W + B_W;
    localparam int T_W         = 36;
    localparam int REM_W       = 8;
    localparam int DIV_STEPS   = 8;
    localparam int DIV_CYCLES  = VAL_W / DIV_STEPS;
    localparam int DCNT_W      = $clog2(DIV_CYCLES);
    localparam int GLOB_LEN    = 12;
    localparam int AXIS_LEN    = 21;
    localparam int GSTEP_W     = $clog2(GLOB_LEN);
    localparam int STEP_W      = $clog2(AXIS_LEN);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [IDX_W-1:0] MOM_ONE  = 4'd0;
    localparam logic [IDX_W-1:0] MOM_X    = 4'd1;
    localparam logic [IDX_W-1:0] MOM_X2   = 4'd4;
    localparam logic [IDX_W-1:0] MOM_XY   = 4'd7;
    localparam logic [IDX_W-1:0] MOM_LAST = IDX_W'(NUM_MOMENTS - 1);

    typedef enum logic [5:0] {
        OP_NOP,
        OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
        OP_NXA, OP_NXB, OP_NYA, OP_NYB, OP_NZA, OP_NZB,
        OP_S01, OP_F1, OP_SQ0, OP_PART, OP_F2, OP_T3, OP_F3A, OP_F3B,
        OP_H0, OP_G0, OP_S0, OP_H1, OP_G1, OP_S1, OP_H2, OP_G2, OP_S2,
        OP_TF1, OP_TF2, OP_TF3, OP_TS
    } t_op;

    localparam t_op GLOB_OPS [GLOB_LEN] = '{
        OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
        OP_NXA, OP_NXB, OP_NYA, OP_NYB, OP_NZA, OP_NZB
    };

    localparam t_op AXIS_OPS [AXIS_LEN] = '{
        OP_S01, OP_F1, OP_SQ0, OP_PART, OP_F2, OP_T3, OP_F3A, OP_F3B,
        OP_H0, OP_G0, OP_S0, OP_H1, OP_G1, OP_S1, OP_H2, OP_G2, OP_S2,
        OP_TF1, OP_TF2, OP_TF3, OP_TS
    };

    typedef struct packed {
        logic               capture;
        t_op                op;
        logic [1:0]         axis;
        logic               div_load;
        logic               div_step;
        logic               out_load;
        logic [IDX_W-1:0]   moment;
        logic               clear;
    } t_cmd;

    typedef struct packed {
        logic [FIELD_W-1:0] ax;
        logic [FIELD_W-1:0] ay;
        logic [FIELD_W-1:0] az;
        logic [FIELD_W-1:0] bx;
        logic [FIELD_W-1:0] by;
        logic [FIELD_W-1:0] bz;
        logic [FIELD_W-1:0] cx;
        logic [FIELD_W-1:0] cy;
        logic [FIELD_W-1:0] cz;
    } t_tri;

    typedef struct packed {
        logic [IDX_W-1:0]   moment_index;
        logic [VAL_W-1:0]   moment_value;
        logic               saturated;
        logic               last_result;
    } t_res;

    function automatic logic [REM_W-2:0] divisor_of(input logic [IDX_W-1:0] k);
        logic [REM_W-2:0] d;
        case (k)
            4'd0:                   d = 7'd6;
            4'd1, 4'd2, 4'd3:       d = 7'd24;
            4'd4, 4'd5, 4'd6:       d = 7'd60;
            default:                d = 7'd120;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/mvi_if.sv]
// ----------------------------------------------------------------------------
// mvi_if
// valid/ready channels for triangle words in and moment words out
// ----------------------------------------------------------------------------
interface mvi_in_if;
    import mvi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  ax;
    logic signed [FIELD_W-1:0]  ay;
    logic signed [FIELD_W-1:0]  az;
    logic signed [FIELD_W-1:0]  bx;
    logic signed [FIELD_W-1:0]  by;
    logic signed [FIELD_W-1:0]  bz;
    logic signed [FIELD_W-1:0]  cx;
    logic signed [FIELD_W-1:0]  cy;
    logic signed [FIELD_W-1:0]  cz;
    logic                       last_triangle;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                    output ready);
endinterface

interface mvi_out_if;
    import mvi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [IDX_W-1:0]           moment_index;
    logic signed [VAL_W-1:0]    moment_value;
    logic                       saturated;
    logic                       last_result;

    modport source (output valid, moment_index, moment_value, saturated, last_result,
                    input ready);
    modport sink   (input valid, moment_index, moment_value, saturated, last_result,
                    output ready);
endinterface

[hw/rtl/mvi_ctrl.sv]
// ----------------------------------------------------------------------------
// mvi_ctrl
// sequencer: steps the shared multiply-add through one triangle, then walks
// the ten moments through divide and output on the last triangle
// ----------------------------------------------------------------------------
module mvi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_last,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output mvi_pkg::t_cmd   o_cmd
);
    import mvi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_GLOB, S_AXIS, S_DRAIN, S_DLOAD, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic [1:0]         r_axis;
    logic [IDX_W-1:0]   r_moment;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_axis   <= AXIS_X;
            r_moment <= '0;
            r_dcnt   <= '0;
            r_last   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last  <= i_last;
                        r_step  <= '0;
                        r_state <= S_GLOB;
                    end
                end
                S_GLOB: begin
                    if (r_step == STEP_W'(GLOB_LEN - 1)) begin
                        r_step  <= '0;
                        r_axis  <= AXIS_X;
                        r_state <= S_AXIS;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_AXIS: begin
                    if (r_step == STEP_W'(AXIS_LEN - 1)) begin
                        r_step <= '0;
                        if (r_axis == AXIS_Z) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_moment <= '0;
                    r_state  <= r_last ? S_DLOAD : S_IDLE;
                end
                S_DLOAD: begin
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(DIV_CYCLES - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_moment == MOM_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_moment <= r_moment + 1'b1;
                            r_state  <= S_DLOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NOP;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        if (r_state == S_GLOB) begin
            o_cmd.op = GLOB_OPS[r_step[GSTEP_W-1:0]];
        end else if (r_state == S_AXIS) begin
            o_cmd.op = AXIS_OPS[r_step];
        end
        o_cmd.axis     = r_axis;
        o_cmd.div_load = (r_state == S_DLOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_FIN);
        o_cmd.moment   = r_moment;
        o_cmd.clear    = (r_state == S_OUT) && i_out_ready && (r_moment == MOM_LAST);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[hw/rtl/mvi_dp.sv]
// ----------------------------------------------------------------------------
// mvi_dp
// datapath: vertex registers, shared multiply-add with named temporaries,
// saturating moment accumulators and an eight-bit-per-cycle constant divider
// ----------------------------------------------------------------------------
module mvi_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mvi_pkg::t_cmd   i_cmd,
    input  mvi_pkg::t_tri   i_tri,
    output mvi_pkg::t_res   o_res
);
    import mvi_pkg::*;

    logic signed [COORD_BITS-1:0] r_x0, r_x1, r_x2, r_y0, r_y1, r_y2, r_z0, r_z1, r_z2;
    logic signed [T_W-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [T_W-1:0] r_nx, r_ny, r_nz, r_tmp;
    logic signed [T_W-1:0] r_s01, r_f1, r_sq0, r_part, r_f2, r_f3, r_h, r_g, r_s;

    logic signed [COORD_BITS-1:0] w0, w1, w2, v0, v1, v2;
    logic signed [T_W-1:0]  nsel;
    logic signed [A_W-1:0]  sa;
    logic signed [B_W-1:0]  sb;
    logic signed [T_W-1:0]  sc;
    logic signed [P_W-1:0]  prod;
    logic signed [T_W-1:0]  res;

    logic [VAL_W-1:0]       r_term;
    logic                   r_term_vld;
    logic [IDX_W-1:0]       r_term_idx;
    logic [VAL_W-1:0]       r_acc [NUM_MOMENTS];
    logic                   r_flag;
    logic [IDX_W-1:0]       rd_idx;
    logic [VAL_W-1:0]       acc_rd;
    logic [VAL_W:0]         sum;
    logic                   ovf;
    logic [VAL_W-1:0]       sat_val;

    logic [VAL_W-1:0]       r_q;
    logic [REM_W-1:0]       r_rem;
    logic                   r_neg;
    logic [VAL_W-1:0]       n_q;
    logic [REM_W-1:0]       n_rem;
    logic [REM_W-2:0]       dv;
    t_res                   r_res;

    localparam logic signed [B_W-1:0] ONE_B = B_W'(1);

    // axis and neighbor-axis selection
    always_comb begin
        case (i_cmd.axis)
            AXIS_X: begin
                w0 = r_x0; w1 = r_x1; w2 = r_x2;
                v0 = r_y0; v1 = r_y1; v2 = r_y2;
                nsel = r_nx;
            end
            AXIS_Y: begin
                w0 = r_y0; w1 = r_y1; w2 = r_y2;
                v0 = r_z0; v1 = r_z1; v2 = r_z2;
                nsel = r_ny;
            end
            default: begin
                w0 = r_z0; w1 = r_z1; w2 = r_z2;
                v0 = r_x0; v1 = r_x1; v2 = r_x2;
                nsel = r_nz;
            end
        endcase
    end

    // operand select for a*b + c
    always_comb begin
        sa = '0;
        sb = '0;
        sc = '0;
        case (i_cmd.op)
            OP_E1X: begin sa = A_W'(r_x1); sb = ONE_B; sc = -T_W'(r_x0); end
            OP_E1Y: begin sa = A_W'(r_y1); sb = ONE_B; sc = -T_W'(r_y0); end
            OP_E1Z: begin sa = A_W'(r_z1); sb = ONE_B; sc = -T_W'(r_z0); end
            OP_E2X: begin sa = A_W'(r_x2); sb = ONE_B; sc = -T_W'(r_x0); end
            OP_E2Y: begin sa = A_W'(r_y2); sb = ONE_B; sc = -T_W'(r_y0); end
            OP_E2Z: begin sa = A_W'(r_z2); sb = ONE_B; sc = -T_W'(r_z0); end
            OP_NXA: begin sa = A_W'(r_e1z); sb = B_W'(r_e2y); end
            OP_NXB: begin sa = A_W'(r_e1y); sb = B_W'(r_e2z); sc = -r_tmp; end
            OP_NYA: begin sa = A_W'(r_e1x); sb = B_W'(r_e2z); end
            OP_NYB: begin sa = A_W'(r_e1z); sb = B_W'(r_e2x); sc = -r_tmp; end
            OP_NZA: begin sa = A_W'(r_e1y); sb = B_W'(r_e2x); end
            OP_NZB: begin sa = A_W'(r_e1x); sb = B_W'(r_e2y); sc = -r_tmp; end
            OP_S01: begin sa = A_W'(w0); sb = ONE_B; sc = T_W'(w1); end
            OP_F1:  begin sa = A_W'(w2); sb = ONE_B; sc = r_s01; end
            OP_SQ0: begin sa = A_W'(w0); sb = B_W'(w0); end
            OP_PART: begin sa = A_W'(w1); sb = B_W'(r_s01); sc = r_sq0; end
            OP_F2:  begin sa = A_W'(w2); sb = B_W'(r_f1); sc = r_part; end
            OP_T3:  begin sa = A_W'(w0); sb = B_W'(r_sq0); end
            OP_F3A: begin sa = A_W'(w1); sb = B_W'(r_part); sc = r_f3; end
            OP_F3B: begin sa = A_W'(w2); sb = B_W'(r_f2); sc = r_f3; end
            OP_H0:  begin sa = A_W'(w0); sb = ONE_B; sc = r_f1; end
            OP_G0:  begin sa = A_W'(w0); sb = B_W'(r_h); sc = r_f2; end
            OP_S0:  begin sa = A_W'(v0); sb = B_W'(r_g); end
            OP_H1:  begin sa = A_W'(w1); sb = ONE_B; sc = r_f1; end
            OP_G1:  begin sa = A_W'(w1); sb = B_W'(r_h); sc = r_f2; end
            OP_S1:  begin sa = A_W'(v1); sb = B_W'(r_g); sc = r_s; end
            OP_H2:  begin sa = A_W'(w2); sb = ONE_B; sc = r_f1; end
            OP_G2:  begin sa = A_W'(w2); sb = B_W'(r_h); sc = r_f2; end
            OP_S2:  begin sa = A_W'(v2); sb = B_W'(r_g); sc = r_s; end
            OP_TF1: begin sa = A_W'(nsel); sb = B_W'(r_f1); end
            OP_TF2: begin sa = A_W'(nsel); sb = B_W'(r_f2); end
            OP_TF3: begin sa = A_W'(nsel); sb = B_W'(r_f3); end
            OP_TS:  begin sa = A_W'(nsel); sb = B_W'(r_s); end
            default: begin sa = '0; sb = '0; sc = '0; end
        endcase
    end

    assign prod = sa * sb;
    assign res  = T_W'(prod) + sc;

    // vertex capture and temporary writeback
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0 <= i_tri.ax[COORD_BITS-1:0];
            r_y0 <= i_tri.ay[COORD_BITS-1:0];
            r_z0 <= i_tri.az[COORD_BITS-1:0];
            r_x1 <= i_tri.bx[COORD_BITS-1:0];
            r_y1 <= i_tri.by[COORD_BITS-1:0];
            r_z1 <= i_tri.bz[COORD_BITS-1:0];
            r_x2 <= i_tri.cx[COORD_BITS-1:0];
            r_y2 <= i_tri.cy[COORD_BITS-1:0];
            r_z2 <= i_tri.cz[COORD_BITS-1:0];
        end
        case (i_cmd.op)
            OP_E1X: r_e1x <= res;
            OP_E1Y: r_e1y <= res;
            OP_E1Z: r_e1z <= res;
            OP_E2X: r_e2x <= res;
            OP_E2Y: r_e2y <= res;
            OP_E2Z: r_e2z <= res;
            OP_NXA, OP_NYA, OP_NZA: r_tmp <= res;
            OP_NXB: r_nx <= res;
            OP_NYB: r_ny <= res;
            OP_NZB: r_nz <= res;
            OP_S01: r_s01 <= res;
            OP_F1:  r_f1 <= res;
            OP_SQ0: r_sq0 <= res;
            OP_PART: r_part <= res;
            OP_F2:  r_f2 <= res;
            OP_T3, OP_F3A, OP_F3B: r_f3 <= res;
            OP_H0, OP_H1, OP_H2: r_h <= res;
            OP_G0, OP_G1, OP_G2: r_g <= res;
            OP_S0, OP_S1, OP_S2: r_s <= res;
            default: ;
        endcase
    end

    // weighted term register
    always_ff @(posedge i_clk) begin
        r_term <= VAL_W'(prod);
        case (i_cmd.op)
            OP_TF1: r_term_idx <= MOM_ONE;
            OP_TF2: r_term_idx <= MOM_X + IDX_W'(i_cmd.axis);
            OP_TF3: r_term_idx <= MOM_X2 + IDX_W'(i_cmd.axis);
            default: r_term_idx <= MOM_XY + IDX_W'(i_cmd.axis);
        endcase
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
        end else begin
            r_term_vld <= ((i_cmd.op == OP_TF1) && (i_cmd.axis == AXIS_X))
                || (i_cmd.op == OP_TF2) || (i_cmd.op == OP_TF3) || (i_cmd.op == OP_TS);
        end
    end

    // saturating accumulate
    assign rd_idx  = r_term_vld ? r_term_idx : i_cmd.moment;
    assign acc_rd  = r_acc[rd_idx];
    assign sum     = {acc_rd[VAL_W-1], acc_rd} + {r_term[VAL_W-1], r_term};
    assign ovf     = sum[VAL_W] != sum[VAL_W-1];
    assign sat_val = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < NUM_MOMENTS; i++) begin
                r_acc[i] <= '0;
            end
            r_flag <= 1'b0;
        end else if (r_term_vld) begin
            r_acc[rd_idx] <= ovf ? sat_val : sum[VAL_W-1:0];
            r_flag        <= r_flag | ovf;
        end
    end

    // restoring divide by a small constant, eight quotient bits a cycle
    assign dv = divisor_of(i_cmd.moment);

    always_comb begin
        logic [REM_W-1:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t   = {n_rem[REM_W-2:0], n_q[VAL_W-1]};
            n_q = {n_q[VAL_W-2:0], 1'b0};
            if (t >= {1'b0, dv}) begin
                t      = t - {1'b0, dv};
                n_q[0] = 1'b1;
            end
            n_rem = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= acc_rd[VAL_W-1];
            r_q   <= acc_rd[VAL_W-1] ? (~acc_rd + 1'b1) : acc_rd;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_res.moment_index <= i_cmd.moment;
            r_res.moment_value <= r_neg ? (~r_q + 1'b1) : r_q;
            r_res.saturated    <= r_flag;
            r_res.last_result  <= (i_cmd.moment == MOM_LAST);
        end
    end

    assign o_res = r_res;

endmodule

[hw/rtl/mesh_volume_integrals_top.sv]
// ----------------------------------------------------------------------------
// mesh_volume_integrals_top
// volume integrals of a closed triangle mesh with integer vertices
// ----------------------------------------------------------------------------
// One triangle word is taken at a time. It is captured, then runs through
// 75 steps of the single shared multiply-add unit (edges, normal, then the
// per-axis subexpressions and weighted terms), and the last term then lands
// in the saturating accumulators. The multiply-add sequence sets how long a
// triangle holds the block. A word marked last_triangle then returns ten
// moment words, each passing through accumulator read, the divider steps at
// eight quotient bits each, output load and presentation, plus any output
// stall; the sums and the saturation flag clear after the tenth word is taken.
// No triangle word is accepted until then.
module mesh_volume_integrals_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mvi_in_if.sink          i_in,
    mvi_out_if.source       o_out
);
    import mvi_pkg::*;

    t_cmd   cmd;
    t_tri   tri_w;
    t_res   res;
    logic   in_ready;
    logic   out_valid;

    assign tri_w.ax = i_in.ax;
    assign tri_w.ay = i_in.ay;
    assign tri_w.az = i_in.az;
    assign tri_w.bx = i_in.bx;
    assign tri_w.by = i_in.by;
    assign tri_w.bz = i_in.bz;
    assign tri_w.cx = i_in.cx;
    assign tri_w.cy = i_in.cy;
    assign tri_w.cz = i_in.cz;

    mvi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last      (i_in.last_triangle),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    mvi_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_tri   (tri_w),
        .o_res   (res)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.moment_index = res.moment_index;
    assign o_out.moment_value = res.moment_value;
    assign o_out.saturated    = res.saturated;
    assign o_out.last_result  = res.last_result;

    // no triangle accepted while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("triangle ready while results pending");

    // final word carries the last moment index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_result) |-> (o_out.moment_index == MOM_LAST))
        else $error("last_result on wrong moment");

    // block is free again right after the final word
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_result) |=> i_in.ready)
        else $error("block not idle after final word");

    // accumulate and divide never share the accumulator read
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_load |-> !cmd.capture && (cmd.op == OP_NOP))
        else $error("divide load overlaps triangle work");

endmodule

[test/tb_mesh_volume_integrals_top.sv]
// ----------------------------------------------------------------------------
// tb_mesh_volume_integrals_top
// The block takes triangles one word at a time and returns ten moment words
// when a word closes a mesh. A scoreboard class keeps its own saturating sums.
// For each accepted triangle it updates those sums. On a closing triangle it
// queues the ten expected moment words. Each returned word is compared field
// by field with the oldest expected word. The stimulus has a directed part
// with extreme and degenerate triangles, and random meshes. Both sides idle
// at random in the first two phases; the last phase runs without idling.
// ----------------------------------------------------------------------------
module tb_mesh_volume_integrals_top;
    import mvi_pkg::*;

    typedef struct {
        t_tri coords;
        logic last;
    } t_tri_word;

    class moment_scoreboard;
        longint  sums [NUM_MOMENTS];
        bit      sat_flag;
        t_res    expected_words [$];
        int      mismatches;

        function new();
            clear_sums();
            mismatches = 0;
        endfunction

        function void clear_sums();
            foreach (sums[k]) sums[k] = 0;
            sat_flag = 0;
        endfunction

        function longint divisor(int k);
            if (k == 0) return 6;
            if (k < 4) return 24;
            if (k < 7) return 60;
            return 120;
        endfunction

        function longint coord_of(logic [FIELD_W-1:0] raw);
            logic signed [COORD_BITS-1:0] c;
            c = raw[COORD_BITS-1:0];
            return c;
        endfunction

        function void sat_accumulate(int k, longint term);
            longint s;
            s = sums[k] + term;
            if (sums[k][63] == term[63] && s[63] != term[63]) begin
                sums[k] = term[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
                sat_flag = 1;
            end else begin
                sums[k] = s;
            end
        endfunction

        function void axis_sums(longint w0, longint w1, longint w2,
                                output longint f1, output longint f2, output longint f3,
                                output longint g0, output longint g1, output longint g2);
            longint s01, part;
            s01  = w0 + w1;
            part = w0 * w0 + w1 * s01;
            f1   = s01 + w2;
            f2   = part + w2 * f1;
            f3   = w0 * w0 * w0 + w1 * part + w2 * f2;
            g0   = f2 + w0 * (f1 + w0);
            g1   = f2 + w1 * (f1 + w1);
            g2   = f2 + w2 * (f1 + w2);
        endfunction

        function void note_triangle(t_tri_word w);
            longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
            longint nx, ny, nz;
            longint f1x, f2x, f3x, g0x, g1x, g2x;
            longint f1y, f2y, f3y, g0y, g1y, g2y;
            longint f1z, f2z, f3z, g0z, g1z, g2z;
            t_res r;
            x0 = coord_of(w.coords.ax); y0 = coord_of(w.coords.ay); z0 = coord_of(w.coords.az);
            x1 = coord_of(w.coords.bx); y1 = coord_of(w.coords.by); z1 = coord_of(w.coords.bz);
            x2 = coord_of(w.coords.cx); y2 = coord_of(w.coords.cy); z2 = coord_of(w.coords.cz);
            nx = (y1 - y0) * (z2 - z0) - (z1 - z0) * (y2 - y0);
            ny = (z1 - z0) * (x2 - x0) - (x1 - x0) * (z2 - z0);
            nz = (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
            axis_sums(x0, x1, x2, f1x, f2x, f3x, g0x, g1x, g2x);
            axis_sums(y0, y1, y2, f1y, f2y, f3y, g0y, g1y, g2y);
            axis_sums(z0, z1, z2, f1z, f2z, f3z, g0z, g1z, g2z);
            sat_accumulate(0, nx * f1x);
            sat_accumulate(1, nx * f2x);
            sat_accumulate(2, ny * f2y);
            sat_accumulate(3, nz * f2z);
            sat_accumulate(4, nx * f3x);
            sat_accumulate(5, ny * f3y);
            sat_accumulate(6, nz * f3z);
            sat_accumulate(7, nx * (y0 * g0x + y1 * g1x + y2 * g2x));
            sat_accumulate(8, ny * (z0 * g0y + z1 * g1y + z2 * g2y));
            sat_accumulate(9, nz * (x0 * g0z + x1 * g1z + x2 * g2z));
            if (w.last) begin
                for (int k = 0; k < NUM_MOMENTS; k++) begin
                    r.moment_index = IDX_W'(k);
                    r.moment_value = sums[k] / divisor(k);
                    r.saturated    = sat_flag;
                    r.last_result  = (k == NUM_MOMENTS - 1);
                    expected_words.insert(expected_words.size(), r);
                end
                clear_sums();
            end
        endfunction

        function void check_word(t_res got);
            t_res exp_w;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected moment word: index %0d value %0d",
                             got.moment_index, $signed(got.moment_value));
                return;
            end
            exp_w = expected_words.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"moment word mismatch: exp idx %0d val %0d sat %0b last %0b,",
                              " got idx %0d val %0d sat %0b last %0b"},
                             exp_w.moment_index, $signed(exp_w.moment_value),
                             exp_w.saturated, exp_w.last_result,
                             got.moment_index, $signed(got.moment_value),
                             got.saturated, got.last_result);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   in_idle_pct;
    int   out_idle_pct;
    moment_scoreboard sb;

    mvi_in_if  in_ch ();
    mvi_out_if out_ch ();

    mesh_volume_integrals_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // result side: sample the handshake, then choose ready for the next cycle
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.moment_index = out_ch.moment_index;
            got.moment_value = out_ch.moment_value;
            got.saturated    = out_ch.saturated;
            got.last_result  = out_ch.last_result;
            sb.check_word(got);
        end
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic send_triangle(t_tri_word w);
        if ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_ch.valid         <= 1'b1;
        in_ch.ax            <= w.coords.ax;
        in_ch.ay            <= w.coords.ay;
        in_ch.az            <= w.coords.az;
        in_ch.bx            <= w.coords.bx;
        in_ch.by            <= w.coords.by;
        in_ch.bz            <= w.coords.bz;
        in_ch.cx            <= w.coords.cx;
        in_ch.cy            <= w.coords.cy;
        in_ch.cz            <= w.coords.cz;
        in_ch.last_triangle <= w.last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_triangle(w);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_tri_word make_tri(int ax, int ay, int az, int bx, int by,
                                           int bz, int cx, int cy, int cz, bit last);
        t_tri_word w;
        w.coords.ax = FIELD_W'(ax); w.coords.ay = FIELD_W'(ay); w.coords.az = FIELD_W'(az);
        w.coords.bx = FIELD_W'(bx); w.coords.by = FIELD_W'(by); w.coords.bz = FIELD_W'(bz);
        w.coords.cx = FIELD_W'(cx); w.coords.cy = FIELD_W'(cy); w.coords.cz = FIELD_W'(cz);
        w.last      = last;
        return w;
    endfunction

    function automatic t_tri_word random_tri(bit last);
        t_tri_word w;
        logic [95:0] raw;
        raw      = {$urandom, $urandom, $urandom};
        w.coords = raw[$bits(t_tri)-1:0];
        w.last   = last;
        return w;
    endfunction

    task automatic send_random_meshes(int n_tri);
        int len;
        while (n_tri > 0) begin
            len = $urandom_range(6, 1);
            for (int j = 0; j < len; j++)
                send_triangle(random_tri(j == len - 1));
            n_tri -= len;
        end
    endtask

    initial begin
        #80_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb = new();
        in_idle_pct  = 34;
        out_idle_pct = 67;
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.ax <= '0; in_ch.ay <= '0; in_ch.az <= '0;
        in_ch.bx <= '0; in_ch.by <= '0; in_ch.bz <= '0;
        in_ch.cx <= '0; in_ch.cy <= '0; in_ch.cz <= '0;
        in_ch.last_triangle <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, degenerate, single and multi-triangle meshes
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_triangle(make_tri(-512, -512, -512, -512, -512, -512, -512, -512, -512, 1));
        send_triangle(make_tri(511, 511, 511, 511, 511, 511, 511, 511, 511, 1));
        send_triangle(make_tri(-512, -512, -512, 511, -512, -512, -512, 511, -512, 0));
        send_triangle(make_tri(-512, -512, -512, -512, -512, 511, 511, -512, -512, 0));
        send_triangle(make_tri(-512, -512, -512, -512, 511, -512, -512, -512, 511, 0));
        send_triangle(make_tri(511, -512, -512, -512, 511, -512, -512, -512, 511, 1));
        send_triangle(make_tri(511, -512, -512, -512, -512, 511, -512, 511, -512, 1));
        send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_tri(-1, 0, 0, 0, -1, 0, 0, 0, -1, 1));
        send_triangle(make_tri(3, -7, 5, 3, -7, 5, 100, 200, -300, 1));
        drain_results();

        send_random_meshes(33);
        drain_results();

        in_idle_pct  = 67;
        out_idle_pct = 34;
        send_random_meshes(33);
        drain_results();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_random_meshes(34);
        drain_results();

        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
